/* hdl/aging_frequency_ranked_list_core_assert.svh */
// Assertion macros used by the ranked list controller
`ifndef AGING_FREQUENCY_RANKED_LIST_CORE_ASSERT_SVH
`define AGING_FREQUENCY_RANKED_LIST_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define AFRL_ASSERT_IMP(lbl, clk_s, rst_s, lhs, rhs, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |-> (rhs)) \
    else $error(msg);
// next-cycle implication
`define AFRL_ASSERT_NEXT(lbl, clk_s, rst_s, lhs, rhs, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

/* hdl/afrl_pkg.sv */
// ----------------------------------------------------------------------------
// afrl_pkg
// Types and constants of the aging ranked list.
// ----------------------------------------------------------------------------
package afrl_pkg;
  localparam int DEF_CAPACITY  = 32;
  localparam int DEF_KEY_BITS  = 32;
  localparam int DEF_RANK_BITS = 16;
  localparam int START_RANK    = 20;
  localparam int GAIN          = 2;
  localparam int AGE_STEP      = 1;
  localparam logic [5:0] MAX_RESET = 6'd30;

  typedef enum logic [1:0] {
    ACT_ACCESS  = 2'd0,
    ACT_LIST    = 2'd1,
    ACT_CLEAR   = 2'd2,
    ACT_PRELOAD = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AGE, ST_SEARCH, ST_MOVE, ST_EVICT, ST_RESULT,
    ST_LIST, ST_PRELOAD, ST_CLEAR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the input word
    logic age;       // age entry at ptr
    logic ptr_clr;   // pointer to zero
    logic ptr_inc;
    logic search;    // compare entry at ptr
    logic insert;    // prepare accessed entry
    logic move;      // one shift step
    logic place;     // write accessed entry at ptr
    logic evict;
    logic append;    // preload write
    logic clear;
    logic emit_acc;
    logic emit_list;
    logic emit_none; // zero result, last
    logic emit_drop;
  } afrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ptr_end;    // ptr at count-1 or beyond
    logic hit;        // key matches at ptr
    logic move_done;  // ptr is 0 or the entry above ranks at least as high
    logic over;       // count above the limit
    logic full;       // count at or above limit
    logic list_zero;
    logic list_last;
    logic empty;
  } afrl_sts_t;
endpackage

/* hdl/afrl_ctrl.sv */
// ----------------------------------------------------------------------------
// afrl_ctrl
// Sequencer: ages, searches, moves and evicts one step a cycle; also runs list, preload and clear.
// ----------------------------------------------------------------------------
module afrl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         action,
  input  afrl_pkg::afrl_sts_t sts,
  output afrl_pkg::afrl_cmd_t cmd,
  output logic               busy
);
  import afrl_pkg::*;
  `include "aging_frequency_ranked_list_core_assert.svh"

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.ptr_clr = 1'b1;
          case (action_t'(action))
            ACT_ACCESS:  state_next = ST_AGE;
            ACT_LIST:    state_next = ST_LIST;
            ACT_CLEAR:   state_next = ST_CLEAR;
            ACT_PRELOAD: state_next = ST_PRELOAD;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_AGE: begin
        if (sts.empty) begin
          cmd.insert  = 1'b1;
          state_next  = ST_MOVE;
        end else begin
          cmd.age = 1'b1;
          if (sts.ptr_end) begin
            cmd.ptr_clr = 1'b1;
            state_next  = ST_SEARCH;
          end else begin
            cmd.ptr_inc = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.hit || sts.ptr_end) begin
          cmd.insert = 1'b1;
          state_next = ST_MOVE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_MOVE: begin
        if (sts.move_done) begin
          cmd.place  = 1'b1;
          state_next = ST_EVICT;
        end else begin
          cmd.move = 1'b1;
        end
      end
      ST_EVICT: begin
        cmd.evict  = sts.over;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        cmd.emit_acc = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_LIST: begin
        if (sts.list_zero) begin
          cmd.emit_none = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.emit_list = 1'b1;
          cmd.ptr_inc   = 1'b1;
          if (sts.list_last) state_next = ST_IDLE;
        end
      end
      ST_PRELOAD: begin
        if (sts.full) cmd.emit_drop = 1'b1;
        else          cmd.append    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CLEAR: begin
        cmd.clear     = 1'b1;
        cmd.emit_none = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `AFRL_ASSERT_IMP(a_load_idle, clk, rst, cmd.load, state == ST_IDLE, "load outside idle")
  `AFRL_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start not taken")
  `AFRL_ASSERT_IMP(a_one_emit, clk, rst, 1'b1,
    $onehot0({cmd.emit_acc, cmd.emit_list, cmd.emit_none, cmd.emit_drop, cmd.append}),
    "two results in one cycle")
endmodule

/* hdl/afrl_datapath.sv */
// ----------------------------------------------------------------------------
// afrl_datapath
// Entry store, pointer, count and result register.
// ----------------------------------------------------------------------------
module afrl_datapath #(
  parameter int CAPACITY  = afrl_pkg::DEF_CAPACITY,
  parameter int KEY_BITS  = afrl_pkg::DEF_KEY_BITS,
  parameter int RANK_BITS = afrl_pkg::DEF_RANK_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  afrl_pkg::afrl_cmd_t  cmd,
  output afrl_pkg::afrl_sts_t  sts,
  input  logic [5:0]           max_entries,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [15:0]          preload_rank,
  input  logic [5:0]           list_limit,
  output logic                 done,
  output logic                 entry_valid,
  output logic [KEY_BITS-1:0]  entry_key,
  output logic [RANK_BITS-1:0] entry_rank,
  output logic [4:0]           position,
  output logic                 was_present,
  output logic                 evicted,
  output logic [KEY_BITS-1:0]  evicted_key,
  output logic [5:0]           entry_count,
  output logic                 last
);
  import afrl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 2);
  localparam int LW = (CW > 6) ? CW : 6;
  localparam logic [RANK_BITS-1:0] RMAX = '1;
  localparam logic [RANK_BITS-1:0] START_R =
    (RANK_BITS >= 6) ? RANK_BITS'(START_RANK) : RMAX;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // entry store (flip-flops: read at the pointer, one above and the tail)
  logic [KEY_BITS-1:0]  keys  [CAPACITY];
  logic [RANK_BITS-1:0] ranks [CAPACITY];
  // key of the extra tail slot, only held until it is evicted
  logic [KEY_BITS-1:0]  spill_key;

  logic [CW-1:0]        count;
  logic [CW-1:0]        ptr;
  logic [KEY_BITS-1:0]  key_q;
  logic [RANK_BITS-1:0] prank_q;
  logic [LW-1:0]        n_q;
  logic [KEY_BITS-1:0]  acc_key;
  logic [RANK_BITS-1:0] acc_rank;
  logic                 present;
  logic                 ev_q;
  logic                 gone;
  logic [KEY_BITS-1:0]  evkey_q;
  logic [CW-1:0]        limit;
  logic [CW-1:0]        tail;
  logic                 in_store;

  logic [AW-1:0]        pa, pm1;
  logic [RANK_BITS-1:0] rank_at, rank_up;
  logic [KEY_BITS-1:0]  key_up;

  // effective limit 1..CAPACITY
  always_comb begin
    if (max_entries == 6'd0)                    limit = CW'(1);
    else if (LW'(max_entries) > LW'(CAPACITY))  limit = CW'(CAPACITY);
    else                                        limit = CW'(max_entries);
  end

  assign pa       = ptr[AW-1:0];
  assign pm1      = AW'(ptr - CW'(1));
  assign rank_at  = ranks[pa];
  assign rank_up  = ranks[pm1];
  assign key_up   = keys[pm1];
  assign tail     = count - CW'(1);
  assign in_store = (ptr < CAP_C);

  // status back to the controller
  assign sts.empty     = (count == '0);
  assign sts.ptr_end   = (ptr + CW'(1) >= count);
  assign sts.hit       = (keys[pa] == key_q);
  assign sts.move_done = (ptr == '0) || (rank_up >= acc_rank);
  assign sts.over      = (count > limit);
  assign sts.full      = (count >= limit);
  assign sts.list_zero = (n_q == '0);
  assign sts.list_last = (LW'(ptr) + LW'(1) >= n_q);

  // list length: min of request, limit and count
  logic [LW-1:0] n_calc;
  always_comb begin
    n_calc = LW'(list_limit);
    if (n_calc > LW'(limit)) n_calc = LW'(limit);
    if (n_calc > LW'(count)) n_calc = LW'(count);
  end

  // store updates; a write one past the store lands in the spill slot
  always_ff @(posedge clk) begin
    if (cmd.age)
      ranks[pa] <= (rank_at >= RANK_BITS'(AGE_STEP)) ? rank_at - RANK_BITS'(AGE_STEP) : '0;
    if (cmd.move) begin
      if (in_store) begin
        keys[pa]  <= key_up;
        ranks[pa] <= rank_up;
      end else begin
        spill_key <= key_up;
      end
    end
    if (cmd.place) begin
      if (in_store) begin
        keys[pa]  <= acc_key;
        ranks[pa] <= acc_rank;
      end else begin
        spill_key <= acc_key;
      end
    end
    if (cmd.append) begin
      keys[count[AW-1:0]]  <= key_q;
      ranks[count[AW-1:0]] <= prank_q;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.emit_acc | cmd.emit_list | cmd.emit_none | cmd.emit_drop | cmd.append;
      if (cmd.ptr_clr)      ptr <= '0;
      else if (cmd.ptr_inc) ptr <= ptr + CW'(1);
      else if (cmd.move)    ptr <= ptr - CW'(1);
      else if (cmd.insert && !(cmd.search && sts.hit)) ptr <= count;
      if (cmd.insert && !(cmd.search && sts.hit)) count <= count + CW'(1);
      else if (cmd.evict)  count <= count - CW'(1);
      else if (cmd.append) count <= count + CW'(1);
      else if (cmd.clear)  count <= '0;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_q   <= key;
      prank_q <= (RANK_BITS >= 16) ? RANK_BITS'(preload_rank)
                 : ((preload_rank > 16'(RMAX)) ? RMAX : RANK_BITS'(preload_rank));
      n_q     <= n_calc;
      present <= 1'b0;
      ev_q    <= 1'b0;
      gone    <= 1'b0;
      evkey_q <= '0;
    end
    if (cmd.insert) begin
      acc_key <= key_q;
      if (cmd.search && sts.hit) begin
        present  <= 1'b1;
        acc_rank <= (RMAX - rank_at < RANK_BITS'(GAIN)) ? RMAX : rank_at + RANK_BITS'(GAIN);
      end else begin
        acc_rank <= START_R;
      end
    end
    if (cmd.evict) begin
      ev_q    <= 1'b1;
      evkey_q <= (tail == CAP_C) ? spill_key : keys[AW'(tail)];
      gone    <= (ptr == tail);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    entry_valid <= 1'b0;
    entry_key   <= '0;
    entry_rank  <= '0;
    position    <= '0;
    was_present <= 1'b0;
    evicted     <= 1'b0;
    evicted_key <= '0;
    entry_count <= 6'(count);
    last        <= 1'b1;
    if (cmd.emit_acc) begin
      entry_valid <= !gone;
      entry_key   <= key_q;
      entry_rank  <= gone ? '0 : acc_rank;
      position    <= gone ? '0 : 5'(ptr);
      was_present <= present;
      evicted     <= ev_q;
      evicted_key <= evkey_q;
    end else if (cmd.emit_list) begin
      entry_valid <= 1'b1;
      entry_key   <= keys[pa];
      entry_rank  <= rank_at;
      position    <= 5'(ptr);
      last        <= sts.list_last;
    end else if (cmd.emit_drop) begin
      entry_key   <= key_q;
    end else if (cmd.append) begin
      entry_valid <= 1'b1;
      entry_key   <= key_q;
      entry_rank  <= prank_q;
      position    <= 5'(count);
      entry_count <= 6'(count + CW'(1));
    end else if (cmd.clear) begin
      entry_count <= '0;
    end
  end
endmodule

/* hdl/aging_frequency_ranked_list_core.sv */
// ----------------------------------------------------------------------------
// aging_frequency_ranked_list_core
// Ranked list of keys with aging, move-up on access and tail eviction.
// ----------------------------------------------------------------------------
// Usage: pulse start with action, key, preload_rank and list_limit while busy
// is low; the word is taken at that edge. Results appear one per cycle on the
// entry_* ports, each marked by done for one cycle; the final one has last.
// The receiver cannot stall, so no hold-off exists.
// Sequence, with n entries held: an access ages each entry, searches for the
// key until a hit or the tail, moves the accessed entry up one place per
// step, then evicts and shows the result; an empty list skips aging and search.
// A list gives one word per entry listed (one zero word when none). Clear and
// preload each give one word. Each result word shows the cycle after the state
// that makes it. The rate is set by the entry store walked one entry a cycle.
// The cfg channel writes max_entries at any edge with cfg_valid high
// (cfg_ready is always high). Reset empties the list and sets max_entries 30.
// ----------------------------------------------------------------------------
module aging_frequency_ranked_list_core #(
  parameter int CAPACITY  = afrl_pkg::DEF_CAPACITY,
  parameter int KEY_BITS  = afrl_pkg::DEF_KEY_BITS,
  parameter int RANK_BITS = afrl_pkg::DEF_RANK_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [15:0]          preload_rank,
  input  logic [5:0]           list_limit,
  output logic                 done,
  output logic                 entry_valid,
  output logic [KEY_BITS-1:0]  entry_key,
  output logic [RANK_BITS-1:0] entry_rank,
  output logic [4:0]           position,
  output logic                 was_present,
  output logic                 evicted,
  output logic [KEY_BITS-1:0]  evicted_key,
  output logic [5:0]           entry_count,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [5:0]           cfg_data
);
  import afrl_pkg::*;

  afrl_cmd_t  cmd;
  afrl_sts_t  sts;
  logic [5:0] max_entries;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst)            max_entries <= MAX_RESET;
    else if (cfg_valid) max_entries <= cfg_data;
  end

  afrl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  afrl_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .RANK_BITS(RANK_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .max_entries(max_entries),
    .key(key), .preload_rank(preload_rank), .list_limit(list_limit),
    .done(done), .entry_valid(entry_valid), .entry_key(entry_key),
    .entry_rank(entry_rank), .position(position), .was_present(was_present),
    .evicted(evicted), .evicted_key(evicted_key), .entry_count(entry_count),
    .last(last)
  );
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the aging ranked list core. A directed table covers
// the corner cases (empty list, saturation, duplicate preloads, eviction of the
// accessed word, dropped preloads, limit lowered below the count). Random
// phases at several max_entries settings follow. Every result word is checked
// against the bench's list model, or against a typed row's own expected word.
// ----------------------------------------------------------------------------
module tb_top;
  import afrl_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PER_PHASE = 55;

  // one result word
  typedef struct packed {
    logic        valid;
    logic [31:0] ekey;
    logic [15:0] rank;
    logic [4:0]  pos;
    logic        present;
    logic        ev;
    logic [31:0] evkey;
    logic [5:0]  count;
    logic        lst;
  } entry_word_t;

  // directed stimulus row; typed rows carry their own expected word
  typedef struct {
    action_t     act;
    logic [31:0] k;
    logic [15:0] prank;
    logic [5:0]  lim;
    bit          typed;
    entry_word_t want;
  } stim_row_t;

  logic        clk, rst, start, busy, done;
  logic [1:0]  action;
  logic [31:0] key;
  logic [15:0] preload_rank;
  logic [5:0]  list_limit;
  logic        entry_valid, was_present, evicted, last;
  logic [31:0] entry_key, evicted_key;
  logic [15:0] entry_rank;
  logic [4:0]  position;
  logic [5:0]  entry_count;
  logic        cfg_valid, cfg_ready;
  logic [5:0]  cfg_data;

  // model of the list
  logic [31:0] list_key [0:32];
  logic [15:0] list_rank [0:32];
  int          list_count;
  logic [5:0]  model_max;

  entry_word_t pending_words[$];
  int          mismatches;
  int          idle_cycles;
  logic [31:0] key_pool [0:11];

  aging_frequency_ranked_list_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action), .key(key),
    .preload_rank(preload_rank), .list_limit(list_limit), .done(done),
    .entry_valid(entry_valid), .entry_key(entry_key), .entry_rank(entry_rank),
    .position(position), .was_present(was_present), .evicted(evicted),
    .evicted_key(evicted_key), .entry_count(entry_count), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic entry_word_t mk_word(logic v, logic [31:0] k, logic [15:0] r,
                                          logic [4:0] p, logic pr, logic e,
                                          logic [31:0] ek, logic [5:0] c, logic l);
    entry_word_t w;
    w = '{valid: v, ekey: k, rank: r, pos: p, present: pr, ev: e, evkey: ek,
          count: c, lst: l};
    return w;
  endfunction

  // advance the list model by one accepted word and queue its results
  function automatic void rank_list_step(action_t act, logic [31:0] k,
                                         logic [15:0] prank, logic [5:0] lim);
    int          lim_eff, at, j, n;
    bit          found, gone, ev;
    logic [31:0] evk, mk;
    logic [15:0] r;
    lim_eff = (model_max < 1) ? 1 : ((model_max > 32) ? 32 : model_max);
    case (act)
      ACT_ACCESS: begin
        found = 0; gone = 0; ev = 0; evk = '0; at = list_count;
        for (int i = 0; i < list_count; i++)
          if (list_rank[i] != 0) list_rank[i] = list_rank[i] - 16'd1;
        for (int i = 0; i < list_count; i++)
          if (!found && list_key[i] == k) begin
            found = 1; at = i;
          end
        if (found) begin
          list_rank[at] = (list_rank[at] >= 16'hfffe) ? 16'hffff : list_rank[at] + 16'd2;
        end else begin
          list_key[at] = k;
          list_rank[at] = 16'(START_RANK);
          list_count++;
        end
        r = list_rank[at]; mk = list_key[at]; j = at;
        while (j > 0 && list_rank[j-1] < r) begin
          list_key[j] = list_key[j-1];
          list_rank[j] = list_rank[j-1];
          j--;
        end
        list_key[j] = mk; list_rank[j] = r;
        if (list_count > lim_eff) begin
          list_count--;
          ev = 1;
          evk = list_key[list_count];
          gone = (j == list_count);
        end
        if (gone)
          pending_words.push_back(mk_word(0, k, 0, 0, found, 1, evk, 6'(list_count), 1));
        else
          pending_words.push_back(mk_word(1, k, r, 5'(j), found, ev, evk,
                                          6'(list_count), 1));
      end
      ACT_LIST: begin
        n = lim;
        if (n > lim_eff) n = lim_eff;
        if (n > list_count) n = list_count;
        if (n == 0)
          pending_words.push_back(mk_word(0, 0, 0, 0, 0, 0, 0, 6'(list_count), 1));
        for (int i = 0; i < n; i++)
          pending_words.push_back(mk_word(1, list_key[i], list_rank[i], 5'(i), 0, 0, 0,
                                          6'(list_count), (i + 1 == n)));
      end
      ACT_CLEAR: begin
        list_count = 0;
        pending_words.push_back(mk_word(0, 0, 0, 0, 0, 0, 0, 0, 1));
      end
      default: begin
        if (list_count >= lim_eff) begin
          pending_words.push_back(mk_word(0, k, 0, 0, 0, 0, 0, 6'(list_count), 1));
        end else begin
          list_key[list_count] = k;
          list_rank[list_count] = prank;
          list_count++;
          pending_words.push_back(mk_word(1, k, prank, 5'(list_count - 1), 0, 0, 0,
                                          6'(list_count), 1));
        end
      end
    endcase
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    entry_word_t got, want;
    if (!rst && done) begin
      got = mk_word(entry_valid, entry_key, entry_rank, position, was_present, evicted,
                    evicted_key, entry_count, last);
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_words.pop_front();
        if (got.valid != want.valid || got.ekey != want.ekey || got.rank != want.rank ||
            got.pos != want.pos || got.present != want.present || got.ev != want.ev ||
            got.evkey != want.evkey || got.count != want.count || got.lst != want.lst) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no result and nothing accepted
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present a word at the falling edge, hold until taken; start stays high
  task automatic send_word(action_t act, logic [31:0] k, logic [15:0] prank,
                           logic [5:0] lim, bit typed, entry_word_t want);
    action <= act; key <= k; preload_rank <= prank; list_limit <= lim;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    rank_list_step(act, k, prank, lim);
    if (typed) begin
      void'(pending_words.pop_back());
      pending_words.push_back(want);
    end
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // write max_entries once the block has drained
  task automatic write_max(logic [5:0] v);
    pause_sender(1);
    while (pending_words.size() != 0 || busy) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    model_max = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(bit pressure);
    int          pick, burst, gap;
    logic [31:0] k;
    logic [15:0] pr;
    action_t     act;
    burst = 0;
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) pause_sender(gap);
        burst = $urandom_range(1, 12);
      end
      burst--;
      if (pressure && i == RANDOM_PER_PHASE / 2) begin
        pause_sender(1);
        while (pending_words.size() != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      k = ($urandom_range(0, 4) == 0) ? $urandom : key_pool[$urandom_range(0, 11)];
      case ($urandom_range(0, 3))
        0: pr = 16'hffff;
        1: pr = 16'h0000;
        default: pr = 16'($urandom);
      endcase
      if (pick < 62) act = ACT_ACCESS;
      else if (pick < 78) act = ACT_LIST;
      else if (pick < 96) act = ACT_PRELOAD;
      else act = ACT_CLEAR;
      send_word(act, k, pr, 6'($urandom_range(0, 63)), 0, '0);
    end
  endtask

  initial begin
    stim_row_t   dir_rows[$];
    logic [5:0]  phase_max [0:6];
    mismatches = 0;
    idle_cycles = 0;
    list_count = 0;
    model_max = MAX_RESET;
    rst = 1'b1; start = 1'b0; action = ACT_ACCESS; key = '0; preload_rank = '0;
    list_limit = '0; cfg_valid = 1'b0; cfg_data = '0;
    for (int i = 0; i < 12; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0; key_pool[1] = 32'hffffffff;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table at the reset setting
    dir_rows = '{
      '{ACT_LIST,    32'h0,        16'h0,    6'd0,  1, mk_word(0,0,0,0,0,0,0,0,1)},
      '{ACT_LIST,    32'h0,        16'h0,    6'd63, 1, mk_word(0,0,0,0,0,0,0,0,1)},
      '{ACT_ACCESS,  32'h0,        16'h0,    6'd0,  1, mk_word(1,0,20,0,0,0,0,1,1)},
      '{ACT_ACCESS,  32'hffffffff, 16'h0,    6'd0,  0, '0},
      '{ACT_ACCESS,  32'h0,        16'h0,    6'd0,  0, '0},
      '{ACT_PRELOAD, 32'ha5a5a5a5, 16'hffff, 6'd0,  0, '0},
      '{ACT_ACCESS,  32'ha5a5a5a5, 16'h0,    6'd0,  0, '0},
      '{ACT_PRELOAD, 32'h12345678, 16'h0,    6'd0,  0, '0},
      '{ACT_PRELOAD, 32'h12345678, 16'h7,    6'd0,  0, '0},
      '{ACT_ACCESS,  32'h12345678, 16'h0,    6'd0,  0, '0},
      '{ACT_LIST,    32'h0,        16'h0,    6'd63, 0, '0},
      '{ACT_LIST,    32'h0,        16'h0,    6'd1,  0, '0},
      '{ACT_CLEAR,   32'h0,        16'h0,    6'd0,  1, mk_word(0,0,0,0,0,0,0,0,1)},
      '{ACT_PRELOAD, 32'h5a5a5a5a, 16'h8000, 6'd0,  0, '0},
      '{ACT_ACCESS,  32'd10,       16'h0,    6'd0,  0, '0},
      '{ACT_ACCESS,  32'd11,       16'h0,    6'd0,  0, '0},
      '{ACT_ACCESS,  32'd12,       16'h0,    6'd0,  0, '0}
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].act, dir_rows[i].k, dir_rows[i].prank, dir_rows[i].lim,
                dir_rows[i].typed, dir_rows[i].want);

    // limit lowered below the count, then the accessed word evicted itself
    write_max(6'd1);
    dir_rows = '{
      '{ACT_ACCESS,  32'd3, 16'h0, 6'd0,  0, '0},
      '{ACT_ACCESS,  32'd3, 16'h0, 6'd0,  0, '0},
      '{ACT_CLEAR,   32'd0, 16'h0, 6'd0,  0, '0},
      '{ACT_ACCESS,  32'd3, 16'h0, 6'd0,  0, '0},
      '{ACT_ACCESS,  32'd3, 16'h0, 6'd0,  0, '0},
      '{ACT_ACCESS,  32'd4, 16'h0, 6'd0,  0, '0},
      '{ACT_PRELOAD, 32'd9, 16'h1, 6'd0,  0, '0},
      '{ACT_LIST,    32'd0, 16'h0, 6'd63, 0, '0}
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].act, dir_rows[i].k, dir_rows[i].prank, dir_rows[i].lim,
                dir_rows[i].typed, dir_rows[i].want);

    // random phases across the setting range
    phase_max = '{6'd32, 6'd0, 6'd63, 6'd5, 6'd30, 6'd17, 6'($urandom_range(1, 32))};
    for (int p = 0; p < 7; p++) begin
      write_max(phase_max[p]);
      send_random(p == 2);
    end

    pause_sender(1);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
